@@ rtl/rlfla_pkg.sv @@
// Package for the run-length free-list allocator.
// Holds function codes, sizes and the sequencer state type.
// No dependencies.
package rlfla_pkg;

  localparam int unsigned NUM_CLASSES = 256;
  localparam int unsigned SLOT_COUNT  = 4096;
  localparam int unsigned CLS_W       = 8;
  localparam int unsigned SLOT_W      = 12;
  localparam int unsigned NODE_W      = 13;
  localparam int unsigned GRP_W       = 4;

  localparam logic [NODE_W-1:0] NIL_NODE = 13'h1000;
  localparam logic [CLS_W-1:0]  MAX_RUN  = 8'd255;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_LOAD  = 2'd1,
    FN_END   = 2'd2,
    FN_ALLOC = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_UP,
    ST_SRCH_DN,
    ST_POP_RD,
    ST_POP_ND,
    ST_POP_WB,
    ST_PUSH_RD,
    ST_PUSH_WR
  } state_t;

endpackage

@@ rtl/run_length_free_list_allocator_unit.sv @@
// Top level of the run-length free-list allocator.
// Depends on rlfla_pkg; holds the class head and node memories.
//
//  channel | ports                                            | transfer
//  input   | in_func, in_slot_dirty, in_request_count         | start && !busy
//  result  | out_start_slot, out_granted_count, out_status    | out_valid, one cycle
//
// Clear, a load without a finished run and an end-load with no pending run stay in idle.
// A load or end-load that pushes a run does a head read, then a node write.
// Allocate: a zero request is refused from idle; else the search scans one 16-class group
// of the non-empty map per cycle, then a pop and, for a remainder, a push follow.
// Synchronous active-low reset empties all classes; no memory clearing pass is needed.
// busy is high while the sequencer works; results cannot be stalled.
module run_length_free_list_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic        in_slot_dirty,
  input  logic [7:0]  in_request_count,
  output logic        out_valid,
  output logic [11:0] out_start_slot,
  output logic [7:0]  out_granted_count,
  output logic        out_status
);

  rlfla_pkg::state_t state_r, state_nxt;

  logic [rlfla_pkg::NUM_CLASSES-1:0] map_r, map_nxt;
  logic [12:0] rec_head_r, rec_head_nxt;
  logic [12:0] fresh_r, fresh_nxt;
  logic [11:0] run_start_r, run_start_nxt;
  logic [12:0] run_last_r, run_last_nxt;
  logic [7:0]  run_len_r, run_len_nxt;
  logic [12:0] load_slot_r, load_slot_nxt;
  logic [7:0]  req_r, req_nxt;
  logic [3:0]  grp_r, grp_nxt;
  logic [7:0]  cls_r, cls_nxt;
  logic [11:0] node_r, node_nxt;
  logic [7:0]  push_len_r, push_len_nxt;
  logic [11:0] push_start_r, push_start_nxt;
  logic        reuse_r, reuse_nxt;
  logic        emit_r, emit_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_start_r, out_start_nxt;
  logic [7:0]  out_granted_r, out_granted_nxt;
  logic        out_status_r, out_status_nxt;

  logic [12:0] cls_mem [rlfla_pkg::NUM_CLASSES];
  logic [24:0] node_mem [rlfla_pkg::SLOT_COUNT];
  logic [12:0] ch_q;
  logic [24:0] nd_q;
  logic        cm_we, nm_we;
  logic [7:0]  cm_waddr, cm_raddr;
  logic [12:0] cm_wdata;
  logic [11:0] nm_waddr, nm_raddr;
  logic [24:0] nm_wdata;

  logic        accept, load_cont, ld_push, end_push;
  logic [7:0]  dn_start;
  logic [15:0] grp_word, up_word, dn_word;
  logic [3:0]  up_idx, dn_idx;
  logic        up_hit, dn_hit;
  logic [11:0] alloc_node;
  logic        alloc_drop;

  function automatic logic [3:0] lowest_set(input logic [15:0] w);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (w[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  function automatic logic [3:0] highest_set(input logic [15:0] w);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (w[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  assign busy   = (state_r != rlfla_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign load_cont = (run_len_r != 8'd0) && (load_slot_r == run_last_r + 13'd1) &&
                     (run_len_r != rlfla_pkg::MAX_RUN);
  assign ld_push   = !load_slot_r[12] && !in_slot_dirty && !load_cont && (run_len_r != 8'd0);
  assign end_push  = (run_len_r != 8'd0);

  assign dn_start = req_r - 8'd1;
  assign grp_word = map_r[{grp_r, 4'h0} +: 16];
  assign up_word  = grp_word & ((grp_r == req_r[7:4]) ? (16'hFFFF << req_r[3:0]) : 16'hFFFF);
  assign dn_word  = grp_word
                  & ((grp_r == dn_start[7:4]) ? (16'hFFFF >> (4'd15 - dn_start[3:0])) : 16'hFFFF)
                  & ((grp_r == 4'd0) ? 16'hFFFE : 16'hFFFF);
  assign up_hit   = |up_word;
  assign dn_hit   = |dn_word;
  assign up_idx   = lowest_set(up_word);
  assign dn_idx   = highest_set(dn_word);

  assign alloc_node = reuse_r ? node_r : (rec_head_r[12] ? fresh_r[11:0] : rec_head_r[11:0]);
  assign alloc_drop = !reuse_r && rec_head_r[12] && fresh_r[12];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlfla_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (rlfla_pkg::func_t'(in_func))
            rlfla_pkg::FN_CLEAR: state_nxt = rlfla_pkg::ST_IDLE;
            rlfla_pkg::FN_LOAD:  if (ld_push) state_nxt = rlfla_pkg::ST_PUSH_RD;
            rlfla_pkg::FN_END:   if (end_push) state_nxt = rlfla_pkg::ST_PUSH_RD;
            rlfla_pkg::FN_ALLOC: if (in_request_count != 8'd0) state_nxt = rlfla_pkg::ST_SRCH_UP;
            default:             state_nxt = rlfla_pkg::ST_IDLE;
          endcase
        end
      end
      rlfla_pkg::ST_SRCH_UP: begin
        if (up_hit) state_nxt = rlfla_pkg::ST_POP_RD;
        else if (grp_r == 4'd15) state_nxt = rlfla_pkg::ST_SRCH_DN;
      end
      rlfla_pkg::ST_SRCH_DN: begin
        if (dn_hit) state_nxt = rlfla_pkg::ST_POP_RD;
        else if (grp_r == 4'd0) state_nxt = rlfla_pkg::ST_IDLE;
      end
      rlfla_pkg::ST_POP_RD: state_nxt = rlfla_pkg::ST_POP_ND;
      rlfla_pkg::ST_POP_ND: state_nxt = rlfla_pkg::ST_POP_WB;
      rlfla_pkg::ST_POP_WB: begin
        state_nxt = (req_r >= cls_r) ? rlfla_pkg::ST_IDLE : rlfla_pkg::ST_PUSH_RD;
      end
      rlfla_pkg::ST_PUSH_RD: state_nxt = rlfla_pkg::ST_PUSH_WR;
      rlfla_pkg::ST_PUSH_WR: state_nxt = rlfla_pkg::ST_IDLE;
      default:               state_nxt = rlfla_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    map_nxt         = map_r;
    rec_head_nxt    = rec_head_r;
    fresh_nxt       = fresh_r;
    run_start_nxt   = run_start_r;
    run_last_nxt    = run_last_r;
    run_len_nxt     = run_len_r;
    load_slot_nxt   = load_slot_r;
    req_nxt         = req_r;
    grp_nxt         = grp_r;
    cls_nxt         = cls_r;
    node_nxt        = node_r;
    push_len_nxt    = push_len_r;
    push_start_nxt  = push_start_r;
    reuse_nxt       = reuse_r;
    emit_nxt        = emit_r;
    out_valid_nxt   = 1'b0;
    out_start_nxt   = out_start_r;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    cm_we    = 1'b0;
    cm_waddr = cls_r;
    cm_wdata = ch_q;
    cm_raddr = (state_r == rlfla_pkg::ST_PUSH_RD) ? push_len_r : cls_r;
    nm_we    = 1'b0;
    nm_waddr = node_r;
    nm_wdata = nd_q;
    nm_raddr = (state_r == rlfla_pkg::ST_POP_ND) ? ch_q[11:0] : rec_head_r[11:0];

    unique case (state_r)
      rlfla_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (rlfla_pkg::func_t'(in_func))
            rlfla_pkg::FN_CLEAR: begin
              map_nxt       = '0;
              rec_head_nxt  = rlfla_pkg::NIL_NODE;
              fresh_nxt     = 13'd0;
              run_start_nxt = 12'd0;
              run_last_nxt  = '1;
              run_len_nxt   = 8'd0;
              load_slot_nxt = 13'd0;
            end
            rlfla_pkg::FN_LOAD: begin
              if (!load_slot_r[12]) begin
                load_slot_nxt = load_slot_r + 13'd1;
                if (!in_slot_dirty) begin
                  if (!load_cont) begin
                    push_len_nxt   = run_len_r;
                    push_start_nxt = run_start_r;
                    reuse_nxt      = 1'b0;
                    emit_nxt       = 1'b0;
                    run_start_nxt  = load_slot_r[11:0];
                    run_len_nxt    = 8'd1;
                  end else begin
                    run_len_nxt = run_len_r + 8'd1;
                  end
                  run_last_nxt = load_slot_r;
                end
              end
            end
            rlfla_pkg::FN_END: begin
              push_len_nxt   = run_len_r;
              push_start_nxt = run_start_r;
              reuse_nxt      = 1'b0;
              emit_nxt       = 1'b0;
              run_start_nxt  = 12'd0;
              run_last_nxt   = '1;
              run_len_nxt    = 8'd0;
              load_slot_nxt  = 13'd0;
            end
            rlfla_pkg::FN_ALLOC: begin
              req_nxt = in_request_count;
              grp_nxt = in_request_count[7:4];
              if (in_request_count == 8'd0) begin
                out_valid_nxt   = 1'b1;
                out_start_nxt   = 12'd0;
                out_granted_nxt = 8'd0;
                out_status_nxt  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      rlfla_pkg::ST_SRCH_UP: begin
        if (up_hit) cls_nxt = {grp_r, up_idx};
        else if (grp_r == 4'd15) grp_nxt = dn_start[7:4];
        else grp_nxt = grp_r + 4'd1;
      end
      rlfla_pkg::ST_SRCH_DN: begin
        if (dn_hit) begin
          cls_nxt = {grp_r, dn_idx};
        end else if (grp_r == 4'd0) begin
          out_valid_nxt   = 1'b1;
          out_start_nxt   = 12'd0;
          out_granted_nxt = 8'd0;
          out_status_nxt  = 1'b1;
        end else begin
          grp_nxt = grp_r - 4'd1;
        end
      end
      rlfla_pkg::ST_POP_RD: ;
      rlfla_pkg::ST_POP_ND: node_nxt = ch_q[11:0];
      rlfla_pkg::ST_POP_WB: begin
        cm_we    = 1'b1;
        cm_waddr = cls_r;
        cm_wdata = nd_q[12:0];
        if (nd_q[12]) map_nxt[cls_r] = 1'b0;
        out_start_nxt  = nd_q[24:13];
        out_status_nxt = 1'b0;
        if (req_r >= cls_r) begin
          out_granted_nxt = cls_r;
          out_valid_nxt   = 1'b1;
          nm_we           = 1'b1;
          nm_waddr        = node_r;
          nm_wdata        = {nd_q[24:13], rec_head_r};
          rec_head_nxt    = {1'b0, node_r};
        end else begin
          out_granted_nxt = req_r;
          push_len_nxt    = cls_r - req_r;
          push_start_nxt  = nd_q[24:13] + {4'd0, req_r};
          reuse_nxt       = 1'b1;
          emit_nxt        = 1'b1;
        end
      end
      rlfla_pkg::ST_PUSH_RD: ;
      rlfla_pkg::ST_PUSH_WR: begin
        out_valid_nxt = emit_r;
        if (!alloc_drop) begin
          nm_we    = 1'b1;
          nm_waddr = alloc_node;
          nm_wdata = {push_start_r, map_r[push_len_r] ? ch_q : rlfla_pkg::NIL_NODE};
          cm_we    = 1'b1;
          cm_waddr = push_len_r;
          cm_wdata = {1'b0, alloc_node};
          map_nxt[push_len_r] = 1'b1;
          if (!reuse_r) begin
            if (!rec_head_r[12]) rec_head_nxt = nd_q[12:0];
            else fresh_nxt = fresh_r + 13'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlfla_pkg::ST_IDLE;
      map_r       <= '0;
      rec_head_r  <= rlfla_pkg::NIL_NODE;
      fresh_r     <= 13'd0;
      run_start_r <= 12'd0;
      run_last_r  <= '1;
      run_len_r   <= 8'd0;
      load_slot_r <= 13'd0;
      reuse_r     <= 1'b0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_r       <= map_nxt;
      rec_head_r  <= rec_head_nxt;
      fresh_r     <= fresh_nxt;
      run_start_r <= run_start_nxt;
      run_last_r  <= run_last_nxt;
      run_len_r   <= run_len_nxt;
      load_slot_r <= load_slot_nxt;
      reuse_r     <= reuse_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    grp_r         <= grp_nxt;
    cls_r         <= cls_nxt;
    node_r        <= node_nxt;
    push_len_r    <= push_len_nxt;
    push_start_r  <= push_start_nxt;
    out_start_r   <= out_start_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (cm_we) cls_mem[cm_waddr] <= cm_wdata;
    ch_q <= cls_mem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (nm_we) node_mem[nm_waddr] <= nm_wdata;
    nd_q <= node_mem[nm_raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_start_slot    = out_start_r;
  assign out_granted_count = out_granted_r;
  assign out_status        = out_status_r;

endmodule

@@ rtl/rlfla_checker.sv @@
// Port-level checks for the run-length free-list allocator.
// Depends on rlfla_pkg; bound to run_length_free_list_allocator_unit.
module rlfla_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_func,
  input logic [7:0] in_request_count,
  input logic       out_valid,
  input logic [11:0] out_start_slot,
  input logic [7:0] out_granted_count,
  input logic       out_status
);

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_granted_count == 8'd0 && out_start_slot == 12'd0)
    else $error("failed result carries data");

  a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> out_granted_count != 8'd0)
    else $error("empty grant");

  a_clear_single: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == rlfla_pkg::FN_CLEAR |=> !busy && !out_valid)
    else $error("clear not single cycle");

  a_zero_req: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == rlfla_pkg::FN_ALLOC && in_request_count == 8'd0
    |=> out_valid && out_status) else $error("zero request not refused");

endmodule

bind run_length_free_list_allocator_unit rlfla_checker u_rlfla_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_func(in_func),
  .in_request_count(in_request_count), .out_valid(out_valid),
  .out_start_slot(out_start_slot), .out_granted_count(out_granted_count),
  .out_status(out_status)
);
